// ----- src/csp_pkg.sv -----
`default_nettype none

package csp_pkg;

    // field widths
    localparam int COORD_BITS    = 32;
    localparam int DIR_BITS      = 16;
    localparam int BOUND_BITS    = 31;
    localparam int INDEX_BITS    = 20;
    localparam int DIR_FRAC      = 14;

    // datapath widths
    localparam int DIFF_BITS     = COORD_BITS + 1;          // p - origin
    localparam int PROD_BITS     = DIFF_BITS + DIR_BITS;    // one cross term
    localparam int CROSS_BITS    = PROD_BITS + 1;           // difference of two terms
    localparam int MAG_BITS      = PROD_BITS - 1;           // |cross component|
    localparam int HALF_BITS     = MAG_BITS / 2;
    localparam int PART_BITS     = 2 * HALF_BITS;
    localparam int SQ_BITS       = 2 * MAG_BITS;
    localparam int DIST_BITS     = SQ_BITS + 2;             // sum of three squares
    localparam int ALIGN_BITS    = 2 * DIR_FRAC;            // bound^2 vs distance^2 scale
    localparam int DHI_BITS      = DIST_BITS - ALIGN_BITS;
    localparam int BSUM_BITS     = BOUND_BITS + 1;
    localparam int BSQ_BITS      = 2 * BSUM_BITS;

    // stream packing
    localparam int S_DATA_BITS   = ((3 * COORD_BITS + INDEX_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS   = ((INDEX_BITS + 1 + 7) / 8) * 8;

    // config port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam int NSTG          = 7;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_RADIUS   = 3'd6,
        REG_BAND_TOL = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] org_x;
        logic signed [COORD_BITS-1:0] org_y;
        logic signed [COORD_BITS-1:0] org_z;
        logic signed [DIR_BITS-1:0]   dir_x;
        logic signed [DIR_BITS-1:0]   dir_y;
        logic signed [DIR_BITS-1:0]   dir_z;
    } axis_t;

    typedef struct packed {
        logic [BSQ_BITS-1:0] upper_sq;    // (r + t)^2
        logic [BSQ_BITS-1:0] lower_sq;    // (r - t)^2, meaningful when r >= t
        logic                lower_free;  // r < t: lower bound always met
    } bound_t;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- src/cylinder_shell_point_filter_unit.sv -----
// An accepted request crosses every stage to its result on m_tvalid.
// Throughput: one point per cycle while m_tready allows; stalls collapse
// bubbles. Seven register stages, each with a 33x16 or 24x24 multiply,
// a wide add or a compare. Bounds settle after a write via value, sum, square regs.
// Reset (aresetn low, synchronous): pipeline emptied, registers to defaults.
`default_nettype none

module cylinder_shell_point_filter_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] pt_x, [63:32] pt_y, [95:64] pt_z, [115:96] pt_index, rest zero
    input  wire logic [csp_pkg::S_DATA_BITS-1:0]   s_tdata,
    // result side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [19:0] out_index, [20] on_shell, rest zero
    output logic [csp_pkg::M_DATA_BITS-1:0]        m_tdata,
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [csp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int X_LO   = 0;
    localparam int Y_LO   = csp_pkg::COORD_BITS;
    localparam int Z_LO   = 2 * csp_pkg::COORD_BITS;
    localparam int IDX_LO = 3 * csp_pkg::COORD_BITS;

    csp_pkg::pipe_ctl_t pc;
    csp_pkg::axis_t     axis;
    csp_pkg::bound_t    bnd;

    logic [csp_pkg::MAG_BITS-1:0]   mag_x, mag_y, mag_z;
    logic [csp_pkg::DIST_BITS-1:0]  dist_sq;

    // index rides alongside the datapath, one tap per stage
    logic [csp_pkg::INDEX_BITS-1:0] idx_reg [csp_pkg::NSTG];
    logic                           on_shell_reg;

    // distance^2 compared against bound^2 scaled up by 2^ALIGN
    logic [csp_pkg::DHI_BITS-1:0]   dist_hi;
    logic                           dist_lo_nz;
    logic [csp_pkg::DHI_BITS-1:0]   upper_ext, lower_ext;
    logic                           upper_ok, lower_ok;

    // config writes never stall
    assign cfg_ready = 1'b1;

    csp_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .pc       (pc)
    );

    csp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .axis      (axis),
        .bnd       (bnd)
    );

    csp_cross_unit u_cross (
        .aclk  (aclk),
        .pc    (pc),
        .pt_x  (s_tdata[X_LO +: csp_pkg::COORD_BITS]),
        .pt_y  (s_tdata[Y_LO +: csp_pkg::COORD_BITS]),
        .pt_z  (s_tdata[Z_LO +: csp_pkg::COORD_BITS]),
        .axis  (axis),
        .mag_x (mag_x),
        .mag_y (mag_y),
        .mag_z (mag_z)
    );

    csp_square_unit u_square (
        .aclk    (aclk),
        .pc      (pc),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .mag_z   (mag_z),
        .dist_sq (dist_sq)
    );

    // final stage: open-band test on squares
    assign dist_hi    = dist_sq[csp_pkg::DIST_BITS-1:csp_pkg::ALIGN_BITS];
    assign dist_lo_nz = |dist_sq[csp_pkg::ALIGN_BITS-1:0];
    assign upper_ext  = csp_pkg::DHI_BITS'(bnd.upper_sq);
    assign lower_ext  = csp_pkg::DHI_BITS'(bnd.lower_sq);

    // bound^2 has zero low bits, so D < B only needs the high part
    assign upper_ok = dist_hi < upper_ext;
    // D > B: high part larger, or equal with any low bit set
    assign lower_ok = bnd.lower_free || (dist_hi > lower_ext)
                      || ((dist_hi == lower_ext) && dist_lo_nz);

    always_ff @(posedge aclk) begin
        if (pc.en[0]) begin
            idx_reg[0] <= s_tdata[IDX_LO +: csp_pkg::INDEX_BITS];
        end
        for (int k = 1; k < csp_pkg::NSTG; k++) begin
            if (pc.en[k]) begin
                idx_reg[k] <= idx_reg[k-1];
            end
        end
        if (pc.en[csp_pkg::NSTG-1]) begin
            on_shell_reg <= upper_ok && lower_ok;
        end
    end

    assign s_tready = pc.en[0];
    assign m_tvalid = pc.vld[csp_pkg::NSTG-1];
    assign m_tdata  = csp_pkg::M_DATA_BITS'({on_shell_reg, idx_reg[csp_pkg::NSTG-1]});

    // an unblocked output must leave the whole pipe open to new requests
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low while output side is free");

    // an accepted request lands in the first stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> pc.vld[0])
        else $error("accepted request lost at stage 0");

    // a held stage keeps its item
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc.vld[csp_pkg::NSTG-2] && !pc.en[csp_pkg::NSTG-2]) |=> pc.vld[csp_pkg::NSTG-2])
        else $error("stalled item dropped");

endmodule

`default_nettype wire

// ----- src/csp_pipe_ctrl.sv -----
`default_nettype none

module csp_pipe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              m_tready,
    output csp_pkg::pipe_ctl_t     pc
);

    logic [csp_pkg::NSTG-1:0] vld_reg;
    logic [csp_pkg::NSTG-1:0] vld_next;
    logic [csp_pkg::NSTG-1:0] en;

    // a stage may load when it is empty or its contents move on
    always_comb begin
        en[csp_pkg::NSTG-1] = !vld_reg[csp_pkg::NSTG-1] || m_tready;
        for (int k = csp_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < csp_pkg::NSTG; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign pc.en  = en;
    assign pc.vld = vld_reg;

endmodule

`default_nettype wire

// ----- src/csp_cfg_regs.sv -----
`default_nettype none

module csp_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [csp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [csp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output csp_pkg::axis_t                         axis,
    output csp_pkg::bound_t                        bnd
);

    csp_pkg::axis_t                  axis_reg;
    logic [csp_pkg::BOUND_BITS-1:0]  radius_reg;
    logic [csp_pkg::BOUND_BITS-1:0]  tol_reg;

    // derived bounds: sum, difference and flag registered from the raw values, squares from those
    logic [csp_pkg::BSUM_BITS-1:0]   bsum_reg;
    logic [csp_pkg::BOUND_BITS-1:0]  bdiff_reg;
    logic                            lfree_reg;
    logic [csp_pkg::BSQ_BITS-1:0]    upper_sq_reg;
    logic [csp_pkg::BSQ_BITS-1:0]    lower_sq_reg;

    logic [csp_pkg::BSQ_BITS-1:0]     upper_sq_next;
    logic [2*csp_pkg::BOUND_BITS-1:0] lower_prod;

    assign upper_sq_next = bsum_reg * bsum_reg;
    assign lower_prod    = bdiff_reg * bdiff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg.org_x <= '0;
            axis_reg.org_y <= '0;
            axis_reg.org_z <= '0;
            axis_reg.dir_x <= '0;
            axis_reg.dir_y <= '0;
            axis_reg.dir_z <= csp_pkg::DIR_BITS'(1 << csp_pkg::DIR_FRAC);
            radius_reg     <= '0;
            tol_reg        <= '0;
            bsum_reg       <= '0;
            bdiff_reg      <= '0;
            lfree_reg      <= 1'b0;
            upper_sq_reg   <= '0;
            lower_sq_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (csp_pkg::cfg_reg_t'(cfg_index))
                    csp_pkg::REG_ORIGIN_X: axis_reg.org_x <= cfg_data[csp_pkg::COORD_BITS-1:0];
                    csp_pkg::REG_ORIGIN_Y: axis_reg.org_y <= cfg_data[csp_pkg::COORD_BITS-1:0];
                    csp_pkg::REG_ORIGIN_Z: axis_reg.org_z <= cfg_data[csp_pkg::COORD_BITS-1:0];
                    csp_pkg::REG_DIR_X:    axis_reg.dir_x <= cfg_data[csp_pkg::DIR_BITS-1:0];
                    csp_pkg::REG_DIR_Y:    axis_reg.dir_y <= cfg_data[csp_pkg::DIR_BITS-1:0];
                    csp_pkg::REG_DIR_Z:    axis_reg.dir_z <= cfg_data[csp_pkg::DIR_BITS-1:0];
                    csp_pkg::REG_RADIUS:   radius_reg     <= cfg_data[csp_pkg::BOUND_BITS-1:0];
                    default:               tol_reg        <= cfg_data[csp_pkg::BOUND_BITS-1:0];
                endcase
            end
            bsum_reg     <= {1'b0, radius_reg} + {1'b0, tol_reg};
            bdiff_reg    <= radius_reg - tol_reg;
            lfree_reg    <= radius_reg < tol_reg;
            upper_sq_reg <= upper_sq_next;
            lower_sq_reg <= csp_pkg::BSQ_BITS'(lower_prod);
        end
    end

    assign axis           = axis_reg;
    assign bnd.upper_sq   = upper_sq_reg;
    assign bnd.lower_sq   = lower_sq_reg;
    assign bnd.lower_free = lfree_reg;

endmodule

`default_nettype wire

// ----- src/csp_cross_unit.sv -----
`default_nettype none

// stages 0..2: offset from origin, cross terms, cross magnitudes
module csp_cross_unit (
    input  wire logic                                  aclk,
    input  wire csp_pkg::pipe_ctl_t                    pc,
    input  wire logic signed [csp_pkg::COORD_BITS-1:0] pt_x,
    input  wire logic signed [csp_pkg::COORD_BITS-1:0] pt_y,
    input  wire logic signed [csp_pkg::COORD_BITS-1:0] pt_z,
    input  wire csp_pkg::axis_t                        axis,
    output logic [csp_pkg::MAG_BITS-1:0]               mag_x,
    output logic [csp_pkg::MAG_BITS-1:0]               mag_y,
    output logic [csp_pkg::MAG_BITS-1:0]               mag_z
);

    logic signed [csp_pkg::DIFF_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic signed [csp_pkg::PROD_BITS-1:0] yz_reg, zy_reg, zx_reg, xz_reg, xy_reg, yx_reg;
    logic [csp_pkg::MAG_BITS-1:0]         mx_reg, my_reg, mz_reg;

    logic signed [csp_pkg::DIR_BITS-1:0]  dx, dy, dz;
    logic [csp_pkg::CROSS_BITS-1:0]       cx, cy, cz;

    function automatic logic [csp_pkg::MAG_BITS-1:0] abs_val(
        input logic [csp_pkg::CROSS_BITS-1:0] v
    );
        logic [csp_pkg::CROSS_BITS-1:0] n;
        n = v[csp_pkg::CROSS_BITS-1] ? (~v + 1'b1) : v;
        return n[csp_pkg::MAG_BITS-1:0];
    endfunction

    assign dx = axis.dir_x;
    assign dy = axis.dir_y;
    assign dz = axis.dir_z;

    // c = a x d
    assign cx = {yz_reg[csp_pkg::PROD_BITS-1], yz_reg} - {zy_reg[csp_pkg::PROD_BITS-1], zy_reg};
    assign cy = {zx_reg[csp_pkg::PROD_BITS-1], zx_reg} - {xz_reg[csp_pkg::PROD_BITS-1], xz_reg};
    assign cz = {xy_reg[csp_pkg::PROD_BITS-1], xy_reg} - {yx_reg[csp_pkg::PROD_BITS-1], yx_reg};

    always_ff @(posedge aclk) begin
        if (pc.en[0]) begin
            ax_reg <= {pt_x[csp_pkg::COORD_BITS-1], pt_x}
                      - {axis.org_x[csp_pkg::COORD_BITS-1], axis.org_x};
            ay_reg <= {pt_y[csp_pkg::COORD_BITS-1], pt_y}
                      - {axis.org_y[csp_pkg::COORD_BITS-1], axis.org_y};
            az_reg <= {pt_z[csp_pkg::COORD_BITS-1], pt_z}
                      - {axis.org_z[csp_pkg::COORD_BITS-1], axis.org_z};
        end
        if (pc.en[1]) begin
            yz_reg <= ay_reg * dz;
            zy_reg <= az_reg * dy;
            zx_reg <= az_reg * dx;
            xz_reg <= ax_reg * dz;
            xy_reg <= ax_reg * dy;
            yx_reg <= ay_reg * dx;
        end
        if (pc.en[2]) begin
            mx_reg <= abs_val(cx);
            my_reg <= abs_val(cy);
            mz_reg <= abs_val(cz);
        end
    end

    assign mag_x = mx_reg;
    assign mag_y = my_reg;
    assign mag_z = mz_reg;

endmodule

`default_nettype wire

// ----- src/csp_square_unit.sv -----
`default_nettype none

// stages 3..5: split squares, recombine, sum of three squares
module csp_square_unit (
    input  wire logic                          aclk,
    input  wire csp_pkg::pipe_ctl_t            pc,
    input  wire logic [csp_pkg::MAG_BITS-1:0]  mag_x,
    input  wire logic [csp_pkg::MAG_BITS-1:0]  mag_y,
    input  wire logic [csp_pkg::MAG_BITS-1:0]  mag_z,
    output logic [csp_pkg::DIST_BITS-1:0]      dist_sq
);

    logic [csp_pkg::MAG_BITS-1:0]  mag [3];
    logic [csp_pkg::PART_BITS-1:0] hh_reg [3];
    logic [csp_pkg::PART_BITS-1:0] hl_reg [3];
    logic [csp_pkg::PART_BITS-1:0] ll_reg [3];
    logic [csp_pkg::SQ_BITS-1:0]   sq_reg [3];
    logic [csp_pkg::DIST_BITS-1:0] dist_reg;

    assign mag[0] = mag_x;
    assign mag[1] = mag_y;
    assign mag[2] = mag_z;

    // m = h*2^H + l, m^2 = h^2*2^2H + 2hl*2^H + l^2
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (pc.en[3]) begin
                hh_reg[i] <= mag[i][csp_pkg::MAG_BITS-1:csp_pkg::HALF_BITS]
                             * mag[i][csp_pkg::MAG_BITS-1:csp_pkg::HALF_BITS];
                hl_reg[i] <= mag[i][csp_pkg::MAG_BITS-1:csp_pkg::HALF_BITS]
                             * mag[i][csp_pkg::HALF_BITS-1:0];
                ll_reg[i] <= mag[i][csp_pkg::HALF_BITS-1:0]
                             * mag[i][csp_pkg::HALF_BITS-1:0];
            end
            if (pc.en[4]) begin
                sq_reg[i] <= (csp_pkg::SQ_BITS'(hh_reg[i]) << (2 * csp_pkg::HALF_BITS))
                             + (csp_pkg::SQ_BITS'(hl_reg[i]) << (csp_pkg::HALF_BITS + 1))
                             + csp_pkg::SQ_BITS'(ll_reg[i]);
            end
        end
        if (pc.en[5]) begin
            dist_reg <= csp_pkg::DIST_BITS'(sq_reg[0]) + csp_pkg::DIST_BITS'(sq_reg[1])
                        + csp_pkg::DIST_BITS'(sq_reg[2]);
        end
    end

    assign dist_sq = dist_reg;

endmodule

`default_nettype wire
